>>> hdl/asm_pkg.sv
// asm_pkg: shared constants, register and mode codes, and pipeline stage types
// for the axis scale mapper. No dependencies; used by axis_scale_mapper_unit.
package asm_pkg;

   // number format
   localparam int VAL_W     = 32;
   localparam int FRAC_BITS = 16;
   localparam int LOG_FRAC  = 20;
   localparam int LOG_W     = LOG_FRAC + 6;

   // log2 mantissa in [1,2) with MANT_FRAC fraction bits
   localparam int MANT_FRAC = 30;
   localparam int MANT_W    = MANT_FRAC + 1;
   localparam int SQ_W      = 2 * MANT_W;
   localparam int POS_W     = 5;
   localparam int LANES     = 3;
   localparam int LANE_VALUE = 0;
   localparam int LANE_DLOW  = 1;
   localparam int LANE_DHIGH = 2;

   // interpolation datapath
   localparam int OP_W   = 34;
   localparam int HALF_W = OP_W / 2;
   localparam int PP_W   = OP_W + HALF_W;
   localparam int PROD_W = 2 * OP_W;
   localparam int Q_W    = 42;
   localparam int REM_W  = OP_W + 1;
   localparam int RES_W  = 44;
   localparam int IP_W   = RES_W - LOG_FRAC;

   // exp2 search and final shift
   localparam int EXP_STAGES = MANT_FRAC * LOG_FRAC;
   localparam int SHIFT_W    = 6;
   localparam int SHIFT_MAX  = 40;
   localparam int RND_W      = SHIFT_MAX + 1;

   localparam logic [MANT_W-1:0] MANT_ONE = MANT_W'(1) << MANT_FRAC;
   localparam logic [Q_W-1:0]    QLIMIT   = Q_W'(1) << (Q_W - 1);
   localparam logic [VAL_W-1:0]  SAT_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0]  SAT_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [VAL_W-1:0]  ONE_VAL  = VAL_W'(1) << FRAC_BITS;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DATA_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DATA_HIGH   = 3'd4;

   // scale modes
   localparam logic [1:0] MODE_LINEAR  = 2'd0;
   localparam logic [1:0] MODE_LOG     = 2'd1;
   localparam logic [1:0] MODE_PERCENT = 2'd2;
   localparam logic [1:0] MODE_INDEXED = 2'd3;

   typedef struct packed {
      logic                valid;
      logic                func;
      logic signed [VAL_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]    p;
      logic [MANT_W-1:0]   m;
      logic [LOG_FRAC-1:0] f;
   } log_lane_type;

   typedef struct packed {
      logic                    valid;
      logic                    func;
      logic signed [VAL_W-1:0] value;
      log_lane_type [LANES-1:0] lane;
   } log_stage_type;

   typedef struct packed {
      logic valid;
      logic bypass;
      logic neg;
      logic use_exp;
   } ctrl_type;

   typedef struct packed {
      ctrl_type                ctrl;
      logic signed [RES_W-1:0] base;
      logic [OP_W-1:0]         a;
      logic [OP_W-1:0]         b;
      logic [OP_W-1:0]         d;
   } setup_type;

   typedef struct packed {
      ctrl_type                ctrl;
      logic signed [RES_W-1:0] base;
      logic [OP_W-1:0]         d;
      logic [PP_W-1:0]         pp_lo;
      logic [PP_W-1:0]         pp_hi;
   } mul_type;

   typedef struct packed {
      ctrl_type                ctrl;
      logic signed [RES_W-1:0] base;
      logic [OP_W-1:0]         d;
      logic [PROD_W-1:0]       prod;
   } prod_type;

   typedef struct packed {
      ctrl_type                ctrl;
      logic                    ovf;
      logic signed [RES_W-1:0] base;
      logic [OP_W-1:0]         d;
      logic [REM_W-1:0]        rem;
      logic [Q_W-1:0]          sh;
   } div_type;

   typedef struct packed {
      ctrl_type                ctrl;
      logic signed [RES_W-1:0] base;
      logic [Q_W-1:0]          q;
   } round_type;

   typedef struct packed {
      logic                    valid;
      logic                    use_exp;
      logic signed [RES_W-1:0] r;
   } add_type;

   typedef struct packed {
      logic                valid;
      logic                use_exp;
      logic                e_ovf;
      logic                e_zero;
      logic [SHIFT_W-1:0]  e_n;
      logic [VAL_W-1:0]    out_pre;
      logic                sat_pre;
      logic [LOG_FRAC-1:0] f;
      logic [MANT_W-1:0]   mbase;
      logic [MANT_W-1:0]   cand;
      log_lane_type        wl;
   } exp_type;

   typedef struct packed {
      logic               valid;
      logic               use_exp;
      logic               e_ovf;
      logic               e_zero;
      logic [SHIFT_W-1:0] e_n;
      logic [VAL_W-1:0]   out_pre;
      logic               sat_pre;
      logic [MANT_W-1:0]  mant;
   } lo_type;

endpackage

>>> hdl/axis_scale_mapper_unit.sv
// axis_scale_mapper_unit: maps signed Q16.16 values between data and screen
// space, linear or logarithmic axis. Depends on asm_pkg.
//
// Usage:
//  - req channel: tdata carries in_value, tuser[0] carries func
//    (0 data to screen, 1 screen to data); one item per accepted beat.
//  - rsp channel: tdata carries out_value, tuser[0] the saturated flag;
//    exactly one result per input item, in order.
//  - csr channel: write csr_data into register csr_index (0 scale_mode,
//    1 screen_low, 2 screen_high, 3 data_low, 4 data_high); always ready.
//    Write only while no item is in flight.
//  - throughput: one item per cycle, sustained while the pipeline advances.
//  - depth: the pipeline length is set by the
//    exp2 search (30 candidate mantissa bits, 20 squaring stages each),
//    the 20-stage log2 squaring chain and the 42-stage restoring divider.
//  - reset: synchronous, clears all valid bits and restores the register
//    reset values (linear, screen 0..1.0, data 0..1.0).
//  - stall: when rsp_tready is low with a result waiting, the pipeline
//    keeps moving while its last stage is empty, then holds; nothing is
//    lost or repeated. req_tready follows the pipeline advance.
module axis_scale_mapper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] in_value
   input  logic [0:0]  req_tuser,    // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] out_value
   output logic [0:0]  rsp_tuser,    // [0] saturated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int VW = asm_pkg::VAL_W;
   localparam int LF = asm_pkg::LOG_FRAC;
   localparam int QW = asm_pkg::Q_W;
   localparam int ES = asm_pkg::EXP_STAGES;

   // helpers
   function automatic logic signed [asm_pkg::OP_W-1:0] op_val(logic signed [VW-1:0] x);
      return {{(asm_pkg::OP_W-VW){x[VW-1]}}, x};
   endfunction

   function automatic logic signed [asm_pkg::OP_W-1:0] op_log(
      logic signed [asm_pkg::LOG_W-1:0] x);
      return {{(asm_pkg::OP_W-asm_pkg::LOG_W){x[asm_pkg::LOG_W-1]}}, x};
   endfunction

   function automatic logic signed [asm_pkg::RES_W-1:0] res_val(logic signed [VW-1:0] x);
      return {{(asm_pkg::RES_W-VW){x[VW-1]}}, x};
   endfunction

   function automatic logic signed [asm_pkg::RES_W-1:0] res_log(
      logic signed [asm_pkg::LOG_W-1:0] x);
      return {{(asm_pkg::RES_W-asm_pkg::LOG_W){x[asm_pkg::LOG_W-1]}}, x};
   endfunction

   function automatic logic [asm_pkg::OP_W-1:0] mag(logic signed [asm_pkg::OP_W-1:0] x);
      return x[asm_pkg::OP_W-1] ? asm_pkg::OP_W'(-x) : asm_pkg::OP_W'(x);
   endfunction

   // leading one search and normalization to a mantissa in [1,2)
   function automatic asm_pkg::log_lane_type norm_lane(logic signed [VW-1:0] x);
      logic [asm_pkg::MANT_W-1:0] u;
      logic [asm_pkg::POS_W-1:0]  p;
      asm_pkg::log_lane_type      r;
      u = (x > 0) ? x[asm_pkg::MANT_W-1:0] : asm_pkg::MANT_W'(1);
      p = '0;
      for (int i = 1; i < asm_pkg::MANT_W; i++) begin
         if (u[i]) p = asm_pkg::POS_W'(i);
      end
      r.p = p;
      r.m = u << (asm_pkg::POS_W'(asm_pkg::MANT_FRAC) - p);
      r.f = '0;
      return r;
   endfunction

   // one squaring step: one more log2 fraction bit
   function automatic asm_pkg::log_lane_type sq_lane(asm_pkg::log_lane_type l);
      logic [asm_pkg::SQ_W-1:0]   sq;
      logic [asm_pkg::MANT_W:0]   w2;
      asm_pkg::log_lane_type      r;
      sq = asm_pkg::SQ_W'(l.m) * asm_pkg::SQ_W'(l.m);
      w2 = sq[asm_pkg::SQ_W-1:asm_pkg::MANT_FRAC];
      r = l;
      r.f = {l.f[LF-2:0], w2[asm_pkg::MANT_W]};
      r.m = w2[asm_pkg::MANT_W] ? w2[asm_pkg::MANT_W:1] : w2[asm_pkg::MANT_W-1:0];
      return r;
   endfunction

   function automatic logic signed [asm_pkg::LOG_W-1:0] log_value(asm_pkg::log_lane_type l);
      logic signed [asm_pkg::LOG_W-1:0] ip;
      ip = asm_pkg::LOG_W'({1'b0, l.p}) - asm_pkg::LOG_W'(asm_pkg::FRAC_BITS);
      return {ip[asm_pkg::LOG_W-1-LF:0], l.f};
   endfunction

   // configuration registers
   logic [1:0]           scale_mode_ff;
   logic signed [VW-1:0] screen_low_ff;
   logic signed [VW-1:0] screen_high_ff;
   logic signed [VW-1:0] data_low_ff;
   logic signed [VW-1:0] data_high_ff;
   logic                 log_ok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff  <= asm_pkg::MODE_LINEAR;
         screen_low_ff  <= '0;
         screen_high_ff <= asm_pkg::ONE_VAL;
         data_low_ff    <= '0;
         data_high_ff   <= asm_pkg::ONE_VAL;
      end else if (csr_valid) begin
         case (csr_index)
            asm_pkg::REG_SCALE_MODE:  scale_mode_ff  <= csr_data[1:0];
            asm_pkg::REG_SCREEN_LOW:  screen_low_ff  <= csr_data;
            asm_pkg::REG_SCREEN_HIGH: screen_high_ff <= csr_data;
            asm_pkg::REG_DATA_LOW:    data_low_ff    <= csr_data;
            asm_pkg::REG_DATA_HIGH:   data_high_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // percentage and indexed modes take the linear path
   assign log_ok = (scale_mode_ff == asm_pkg::MODE_LOG) && (data_low_ff > 0)
                   && (data_high_ff > 0);

   // pipeline registers
   asm_pkg::item_type      in_ff, in_in;
   asm_pkg::log_stage_type lg_ff [0:LF];
   asm_pkg::log_stage_type lg_in [0:LF];
   asm_pkg::setup_type     st_ff, st_in;
   asm_pkg::mul_type       mu_ff, mu_in;
   asm_pkg::prod_type      pr_ff, pr_in;
   asm_pkg::div_type       dv_ff [0:QW];
   asm_pkg::div_type       dv_in [0:QW];
   asm_pkg::round_type     rq_ff, rq_in;
   asm_pkg::add_type       ad_ff, ad_in;
   asm_pkg::exp_type       ex_ff, ex_in;
   asm_pkg::exp_type       ep_ff [0:ES-1];
   asm_pkg::exp_type       ep_in [0:ES-1];
   asm_pkg::lo_type        lo_ff, lo_in;
   logic                   rsp_valid_ff;
   logic [VW-1:0]          rsp_data_ff;
   logic                   rsp_sat_ff;
   logic [VW-1:0]          fin_value;
   logic                   fin_sat;
   logic                   adv;

   // whole pipeline moves unless a valid last stage faces a full output
   assign adv        = rsp_tready || !rsp_valid_ff || !lo_ff.valid;
   assign req_tready = adv;

   // input stage
   always_comb begin
      in_in.valid = req_tvalid;
      in_in.func  = req_tuser[0];
      in_in.value = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) in_ff.valid <= 1'b0;
      else if (adv) in_ff <= in_in;
   end

   // log2 normalize: input value, data_low, data_high in parallel lanes
   always_comb begin
      lg_in[0].valid = in_ff.valid;
      lg_in[0].func  = in_ff.func;
      lg_in[0].value = in_ff.value;
      lg_in[0].lane[asm_pkg::LANE_VALUE] =
         norm_lane((in_ff.value > 0) ? in_ff.value : data_low_ff);
      lg_in[0].lane[asm_pkg::LANE_DLOW]  = norm_lane(data_low_ff);
      lg_in[0].lane[asm_pkg::LANE_DHIGH] = norm_lane(data_high_ff);
   end

   // log2 squaring chain
   for (genvar k = 0; k <= LF; k++) begin : g_log
      if (k > 0) begin : g_sq
         always_comb begin
            lg_in[k] = lg_ff[k-1];
            for (int i = 0; i < asm_pkg::LANES; i++) begin
               lg_in[k].lane[i] = sq_lane(lg_ff[k-1].lane[i]);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) lg_ff[k].valid <= 1'b0;
         else if (adv) lg_ff[k] <= lg_in[k];
      end
   end

   // case selection and interpolation operands
   always_comb begin
      logic signed [asm_pkg::LOG_W-1:0] lv;
      logic signed [asm_pkg::LOG_W-1:0] lmin;
      logic signed [asm_pkg::LOG_W-1:0] lmax;
      logic signed [asm_pkg::OP_W-1:0]  num;
      logic signed [asm_pkg::OP_W-1:0]  span;
      logic signed [asm_pkg::OP_W-1:0]  den;
      lv   = log_value(lg_ff[LF].lane[asm_pkg::LANE_VALUE]);
      lmin = log_value(lg_ff[LF].lane[asm_pkg::LANE_DLOW]);
      lmax = log_value(lg_ff[LF].lane[asm_pkg::LANE_DHIGH]);
      st_in.ctrl.valid   = lg_ff[LF].valid;
      st_in.ctrl.bypass  = 1'b0;
      st_in.ctrl.use_exp = 1'b0;
      num  = '0;
      span = '0;
      den  = asm_pkg::OP_W'(1);
      if (log_ok) begin
         if (lmin == lmax) begin
            // equal logs: target lower bound directly
            st_in.ctrl.bypass = 1'b1;
            st_in.base = lg_ff[LF].func ? res_val(data_low_ff) : res_val(screen_low_ff);
         end else if (lg_ff[LF].func) begin
            // screen to log domain, exp2 afterwards
            st_in.ctrl.use_exp = 1'b1;
            st_in.ctrl.bypass  = (screen_low_ff == screen_high_ff);
            st_in.base = res_log(lmin);
            num  = op_val(lg_ff[LF].value) - op_val(screen_low_ff);
            span = op_log(lmax) - op_log(lmin);
            den  = op_val(screen_high_ff) - op_val(screen_low_ff);
         end else begin
            st_in.base = res_val(screen_low_ff);
            num  = op_log(lv) - op_log(lmin);
            span = op_val(screen_high_ff) - op_val(screen_low_ff);
            den  = op_log(lmax) - op_log(lmin);
         end
      end else if (lg_ff[LF].func) begin
         st_in.ctrl.bypass = (screen_low_ff == screen_high_ff);
         st_in.base = res_val(data_low_ff);
         num  = op_val(lg_ff[LF].value) - op_val(screen_low_ff);
         span = op_val(data_high_ff) - op_val(data_low_ff);
         den  = op_val(screen_high_ff) - op_val(screen_low_ff);
      end else begin
         st_in.ctrl.bypass = (data_low_ff == data_high_ff);
         st_in.base = res_val(screen_low_ff);
         num  = op_val(lg_ff[LF].value) - op_val(data_low_ff);
         span = op_val(screen_high_ff) - op_val(screen_low_ff);
         den  = op_val(data_high_ff) - op_val(data_low_ff);
      end
      st_in.ctrl.neg = num[asm_pkg::OP_W-1] ^ span[asm_pkg::OP_W-1] ^ den[asm_pkg::OP_W-1];
      st_in.a = mag(num);
      st_in.b = mag(span);
      st_in.d = mag(den);
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff.ctrl.valid <= 1'b0;
      else if (adv) st_ff <= st_in;
   end

   // partial products, span split in halves
   always_comb begin
      mu_in.ctrl  = st_ff.ctrl;
      mu_in.base  = st_ff.base;
      mu_in.d     = st_ff.d;
      mu_in.pp_lo = asm_pkg::PP_W'(st_ff.a) * asm_pkg::PP_W'(st_ff.b[asm_pkg::HALF_W-1:0]);
      mu_in.pp_hi = asm_pkg::PP_W'(st_ff.a)
                    * asm_pkg::PP_W'(st_ff.b[asm_pkg::OP_W-1:asm_pkg::HALF_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) mu_ff.ctrl.valid <= 1'b0;
      else if (adv) mu_ff <= mu_in;
   end

   // full product
   always_comb begin
      pr_in.ctrl = mu_ff.ctrl;
      pr_in.base = mu_ff.base;
      pr_in.d    = mu_ff.d;
      pr_in.prod = asm_pkg::PROD_W'(mu_ff.pp_lo)
                   + (asm_pkg::PROD_W'(mu_ff.pp_hi) << asm_pkg::HALF_W);
   end

   always_ff @(posedge clock) begin
      if (reset) pr_ff.ctrl.valid <= 1'b0;
      else if (adv) pr_ff <= pr_in;
   end

   // divider entry: quotient overflow check on the upper product bits
   always_comb begin
      logic [asm_pkg::PROD_W-QW-1:0] top;
      top = pr_ff.prod[asm_pkg::PROD_W-1:QW];
      dv_in[0].ctrl = pr_ff.ctrl;
      dv_in[0].base = pr_ff.base;
      dv_in[0].d    = pr_ff.d;
      dv_in[0].ovf  = asm_pkg::OP_W'(top) >= pr_ff.d;
      dv_in[0].rem  = asm_pkg::REM_W'(top);
      dv_in[0].sh   = pr_ff.prod[QW-1:0];
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k <= QW; k++) begin : g_div
      if (k > 0) begin : g_step
         always_comb begin
            logic [asm_pkg::REM_W-1:0] remx;
            logic                      ge;
            remx = {dv_ff[k-1].rem[asm_pkg::OP_W-1:0], dv_ff[k-1].sh[QW-1]};
            ge   = remx >= {1'b0, dv_ff[k-1].d};
            dv_in[k]     = dv_ff[k-1];
            dv_in[k].rem = ge ? remx - {1'b0, dv_ff[k-1].d} : remx;
            dv_in[k].sh  = {dv_ff[k-1].sh[QW-2:0], ge};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[k].ctrl.valid <= 1'b0;
         else if (adv) dv_ff[k] <= dv_in[k];
      end
   end

   // clip and round the quotient magnitude
   always_comb begin
      logic rnd;
      rnd = {dv_ff[QW].rem, 1'b0} >= {2'b00, dv_ff[QW].d};
      rq_in.ctrl = dv_ff[QW].ctrl;
      rq_in.base = dv_ff[QW].base;
      if (dv_ff[QW].ovf || (dv_ff[QW].sh > asm_pkg::QLIMIT)) rq_in.q = asm_pkg::QLIMIT;
      else rq_in.q = dv_ff[QW].sh + QW'(rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) rq_ff.ctrl.valid <= 1'b0;
      else if (adv) rq_ff <= rq_in;
   end

   // add base with the restored sign
   always_comb begin
      ad_in.valid   = rq_ff.ctrl.valid;
      ad_in.use_exp = rq_ff.ctrl.use_exp;
      if (rq_ff.ctrl.bypass) ad_in.r = rq_ff.base;
      else if (rq_ff.ctrl.neg) ad_in.r = rq_ff.base - asm_pkg::RES_W'(rq_ff.q);
      else ad_in.r = rq_ff.base + asm_pkg::RES_W'(rq_ff.q);
   end

   always_ff @(posedge clock) begin
      if (reset) ad_ff.valid <= 1'b0;
      else if (adv) ad_ff <= ad_in;
   end

   // saturate linear results, split log results into shift and fraction
   always_comb begin
      logic signed [asm_pkg::IP_W-1:0] ip;
      logic signed [asm_pkg::IP_W-1:0] s;
      logic signed [asm_pkg::IP_W-1:0] n;
      logic                            fits;
      ip = asm_pkg::IP_W'(ad_ff.r >>> LF);
      s  = ip + asm_pkg::IP_W'(asm_pkg::FRAC_BITS - asm_pkg::MANT_FRAC);
      n  = -s;
      fits = (ad_ff.r[asm_pkg::RES_W-1:VW-1] == '0) || (ad_ff.r[asm_pkg::RES_W-1:VW-1] == '1);
      ex_in = '0;
      ex_in.valid   = ad_ff.valid;
      ex_in.use_exp = ad_ff.use_exp;
      ex_in.e_ovf   = s > 0;
      ex_in.e_zero  = (s <= 0) && (n > asm_pkg::SHIFT_MAX);
      ex_in.e_n     = n[asm_pkg::SHIFT_W-1:0];
      ex_in.f       = ad_ff.r[LF-1:0];
      ex_in.sat_pre = !fits;
      if (fits) ex_in.out_pre = ad_ff.r[VW-1:0];
      else if (ad_ff.r[asm_pkg::RES_W-1]) ex_in.out_pre = asm_pkg::SAT_MIN;
      else ex_in.out_pre = asm_pkg::SAT_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) ex_ff.valid <= 1'b0;
      else if (adv) ex_ff <= ex_in;
   end

   // exp2 search: one mantissa bit per block, each block re-runs the log2
   // squaring chain on the candidate and compares with the wanted fraction
   for (genvar g = 0; g < ES; g++) begin : g_exp
      localparam int T = g % LF;
      localparam int J = asm_pkg::MANT_FRAC - 1 - g / LF;
      asm_pkg::exp_type src;
      if (g == 0) begin : g_first
         assign src = ex_ff;
      end else begin : g_next
         assign src = ep_ff[g-1];
      end
      if (T == 0) begin : g_cand
         always_comb begin
            logic [asm_pkg::MANT_W-1:0] mb;
            if (g == 0) mb = asm_pkg::MANT_ONE;
            else mb = (src.wl.f <= src.f) ? src.cand : src.mbase;
            ep_in[g]       = src;
            ep_in[g].mbase = mb;
            ep_in[g].cand  = mb | (asm_pkg::MANT_W'(1) << J);
            ep_in[g].wl.p  = '0;
            ep_in[g].wl.m  = mb | (asm_pkg::MANT_W'(1) << J);
            ep_in[g].wl.f  = '0;
            ep_in[g].wl    = sq_lane(ep_in[g].wl);
         end
      end else begin : g_sqr
         always_comb begin
            ep_in[g]    = src;
            ep_in[g].wl = sq_lane(src.wl);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) ep_ff[g].valid <= 1'b0;
         else if (adv) ep_ff[g] <= ep_in[g];
      end
   end

   // last candidate decision
   always_comb begin
      lo_in.valid   = ep_ff[ES-1].valid;
      lo_in.use_exp = ep_ff[ES-1].use_exp;
      lo_in.e_ovf   = ep_ff[ES-1].e_ovf;
      lo_in.e_zero  = ep_ff[ES-1].e_zero;
      lo_in.e_n     = ep_ff[ES-1].e_n;
      lo_in.out_pre = ep_ff[ES-1].out_pre;
      lo_in.sat_pre = ep_ff[ES-1].sat_pre;
      lo_in.mant    = (ep_ff[ES-1].wl.f <= ep_ff[ES-1].f) ? ep_ff[ES-1].cand
                                                          : ep_ff[ES-1].mbase;
   end

   always_ff @(posedge clock) begin
      if (reset) lo_ff.valid <= 1'b0;
      else if (adv) lo_ff <= lo_in;
   end

   // shift the exp2 mantissa into the value format, round half up
   always_comb begin
      logic [asm_pkg::RND_W-1:0] rnd;
      rnd = (asm_pkg::RND_W'(lo_ff.mant)
             + (asm_pkg::RND_W'(1) << (lo_ff.e_n - asm_pkg::SHIFT_W'(1)))) >> lo_ff.e_n;
      fin_value = lo_ff.out_pre;
      fin_sat   = lo_ff.sat_pre;
      if (lo_ff.use_exp) begin
         fin_sat = 1'b0;
         if (lo_ff.e_ovf) begin
            fin_value = asm_pkg::SAT_MAX;
            fin_sat   = 1'b1;
         end else if (lo_ff.e_zero) begin
            fin_value = '0;
         end else if (lo_ff.e_n == '0) begin
            fin_value = VW'(lo_ff.mant);
         end else begin
            fin_value = rnd[VW-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_tready || !rsp_valid_ff) begin
         rsp_valid_ff <= lo_ff.valid;
         rsp_data_ff  <= fin_value;
         rsp_sat_ff   <= fin_sat;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

endmodule

>>> dv/scale_map_checker.sv
// scale_map_checker: watches the req, rsp and csr channels of the axis scale
// mapper, predicts every result and compares it. Depends on asm_pkg.
`timescale 1ns / 100ps
module scale_map_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          errors,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic        sat;
      logic [31:0] value;
   } mapped_type;

   // register shadow
   logic [1:0]         mode;
   logic signed [31:0] scr_lo, scr_hi, dat_lo, dat_hi;

   mapped_type expected_q[$];

   function automatic longint unsigned mag(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   // base + round(num * span / den), ties away from zero on the magnitude
   function automatic longint scaled_offset(longint base, longint num, longint span,
                                            longint den);
      logic [127:0] prod, quo, rmd, d;
      longint unsigned q;
      logic neg;
      neg  = ((num < 0) != (span < 0)) != (den < 0);
      d    = 128'(mag(den));
      prod = 128'(mag(num)) * 128'(mag(span));
      quo  = prod / d;
      rmd  = prod % d;
      if (quo > (128'd1 << 41))
         q = 64'd1 << 41;
      else
         q = quo[63:0] + (((rmd << 1) >= d) ? 64'd1 : 64'd0);
      return neg ? base - longint'(q) : base + longint'(q);
   endfunction

   // fraction bits of log2 by repeated squaring of a [1,2) mantissa
   function automatic longint unsigned log_fraction(longint unsigned m);
      longint unsigned f;
      f = 0;
      for (int k = 0; k < asm_pkg::LOG_FRAC; k++) begin
         m = (m * m) >> 30;
         f = f << 1;
         if (m >= (64'd1 << 31)) begin
            f = f | 1;
            m = m >> 1;
         end
      end
      return f;
   endfunction

   function automatic longint log2_fixed(longint unsigned x);
      int p;
      p = 30;
      while (p > 0 && x[p] == 1'b0)
         p--;
      return longint'(p - asm_pkg::FRAC_BITS) * (longint'(1) << asm_pkg::LOG_FRAC)
           + longint'(log_fraction(x << (30 - p)));
   endfunction

   function automatic longint exp2_fixed(longint l, inout logic sat);
      longint one, ip, s, n;
      longint unsigned f, lo, hi, mid;
      one = longint'(1) << asm_pkg::LOG_FRAC;
      ip  = l >= 0 ? l / one : -((-l + one - 1) / one);
      f   = l - ip * one;
      lo  = 64'd1 << 30;
      hi  = (64'd1 << 31) - 1;
      // largest mantissa whose log fraction does not exceed f
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (log_fraction(mid) <= f)
            lo = mid;
         else
            hi = mid - 1;
      end
      s = ip + asm_pkg::FRAC_BITS - 30;
      if (s >= 1) begin
         sat = 1'b1;
         return 64'h7FFFFFFF;
      end
      if (s == 0)
         return lo;
      n = -s;
      if (n > 40)
         return 0;
      return longint'((lo + (64'd1 << (n - 1))) >> n);
   endfunction

   function automatic longint lerp(longint v, longint sa, longint sb, longint ta,
                                   longint tb);
      if (sa == sb)
         return ta;
      return scaled_offset(ta, v - sa, tb - ta, sb - sa);
   endfunction

   function automatic mapped_type map_point(logic to_data, logic signed [31:0] v);
      longint r, lmin, lmax, lv;
      logic sat;
      mapped_type res;
      sat = 1'b0;
      if (mode == asm_pkg::MODE_LOG && dat_lo > 0 && dat_hi > 0) begin
         lmin = log2_fixed(dat_lo);
         lmax = log2_fixed(dat_hi);
         if (lmin == lmax)
            r = to_data ? dat_lo : scr_lo;
         else if (to_data)
            r = exp2_fixed(lerp(v, scr_lo, scr_hi, lmin, lmax), sat);
         else begin
            lv = log2_fixed(v > 0 ? v : dat_lo);
            r  = scaled_offset(scr_lo, lv - lmin, longint'(scr_hi) - scr_lo,
                               lmax - lmin);
         end
      end else if (to_data)
         r = lerp(v, scr_lo, scr_hi, dat_lo, dat_hi);
      else
         r = lerp(v, dat_lo, dat_hi, scr_lo, scr_hi);
      // clip to the 32-bit range
      if (r > 64'sh7FFFFFFF) begin
         r   = 64'sh7FFFFFFF;
         sat = 1'b1;
      end else if (r < -64'sh80000000) begin
         r   = -64'sh80000000;
         sat = 1'b1;
      end
      res.value = r[31:0];
      res.sat   = sat;
      return res;
   endfunction

   task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
      errors++;
   endtask

   assign pending = expected_q.size();

   // shadow registers, predictions and comparison
   always @(posedge clock) begin
      mapped_type e;
      if (reset) begin
         mode   <= asm_pkg::MODE_LINEAR;
         scr_lo <= '0;
         scr_hi <= asm_pkg::ONE_VAL;
         dat_lo <= '0;
         dat_hi <= asm_pkg::ONE_VAL;
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_q.push_back(map_point(req_tuser[0], req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_q.size() == 0)
               report("unexpected item", 0, rsp_tdata);
            else begin
               e = expected_q.pop_front();
               if (rsp_tdata !== e.value)
                  report("out_value", e.value, rsp_tdata);
               if (rsp_tuser[0] !== e.sat)
                  report("saturated", e.sat, rsp_tuser);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               asm_pkg::REG_SCALE_MODE:  mode   <= csr_data[1:0];
               asm_pkg::REG_SCREEN_LOW:  scr_lo <= csr_data;
               asm_pkg::REG_SCREEN_HIGH: scr_hi <= csr_data;
               asm_pkg::REG_DATA_LOW:    dat_lo <= csr_data;
               asm_pkg::REG_DATA_HIGH:   dat_hi <= csr_data;
               default: ;
            endcase
         end
      end
   end

   initial begin
      errors  = 0;
      checked = 0;
   end

endmodule

>>> dv/axis_scale_mapper_unit_tb.sv
// axis_scale_mapper_unit_tb: drives items and register writes into the axis
// scale mapper over many axis settings. Depends on asm_pkg and scale_map_checker.
`timescale 1ns / 100ps
module axis_scale_mapper_unit_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] in_value
   logic [0:0]  req_tuser = '0;    // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] out_value
   logic [0:0]  rsp_tuser;        // [0] saturated
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   int errors, pending, checked;
   int items_sent, settings_used;
   logic rsp_steady;

   // top's copy of the axis bounds, for aiming stimulus
   logic signed [31:0] scr_lo, scr_hi, dat_lo, dat_hi;

   always #4 clock = ~clock;

   axis_scale_mapper_unit DUT (.*);

   scale_map_checker checker_i (.*);

   // mostly short gaps, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (rsp_steady || gap_len() == 0)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= 1'b0;
   end

   task automatic send_item(logic to_data, logic [31:0] v, logic no_gaps);
      logic rdy;
      int   g;
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= to_data;
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      items_sent++;
      g = no_gaps ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      logic rdy;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do begin
         @(negedge clock);
         rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      case (idx)
         asm_pkg::REG_SCREEN_LOW:  scr_lo = v;
         asm_pkg::REG_SCREEN_HIGH: scr_hi = v;
         asm_pkg::REG_DATA_LOW:    dat_lo = v;
         asm_pkg::REG_DATA_HIGH:   dat_hi = v;
         default: ;
      endcase
   endtask

   task automatic set_axis(logic [1:0] m, logic [31:0] sl, logic [31:0] sh,
                           logic [31:0] dl, logic [31:0] dh);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(asm_pkg::REG_SCALE_MODE, {30'd0, m});
      write_reg(asm_pkg::REG_SCREEN_LOW, sl);
      write_reg(asm_pkg::REG_SCREEN_HIGH, sh);
      write_reg(asm_pkg::REG_DATA_LOW, dl);
      write_reg(asm_pkg::REG_DATA_HIGH, dh);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // value aimed at the bounds of the source space, near zero, or anywhere
   function automatic logic [31:0] pick_value(logic to_data);
      longint lo, hi, span;
      lo = to_data ? scr_lo : dat_lo;
      hi = to_data ? scr_hi : dat_hi;
      if (lo > hi) begin
         span = lo; lo = hi; hi = span;
      end
      span = hi - lo + 1;
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'(lo + longint'({$urandom, $urandom} % span));
         2: return 32'(lo + $signed($urandom_range(16)) - 8);
         3: return 32'(hi + $signed($urandom_range(16)) - 8);
         default: return 32'($signed($urandom_range(32'h200000)) - 32'sh100000);
      endcase
   endfunction

   task automatic run_phase(int count);
      logic no_gaps;
      // extremes of the input, zero and minus one first
      send_item(1'b0, 32'h80000000, 1'b0);
      send_item(1'b0, 32'h7FFFFFFF, 1'b0);
      send_item(1'b1, 32'h80000000, 1'b0);
      send_item(1'b1, 32'h7FFFFFFF, 1'b0);
      send_item(1'b0, 32'h0, 1'b0);
      send_item(1'b1, 32'hFFFFFFFF, 1'b0);
      for (int i = 0; i < count; i++) begin
         logic f;
         if (i % 40 == 0) begin
            no_gaps    = $urandom_range(3) == 0;
            rsp_steady = $urandom_range(3) == 0;
         end
         f = $urandom_range(1);
         send_item(f, pick_value(f), no_gaps);
      end
   endtask

   initial begin
      logic [1:0]  m;
      logic [31:0] dl, dh;
      items_sent    = 0;
      settings_used = 0;
      rsp_steady    = 1'b0;
      scr_lo = '0; scr_hi = asm_pkg::ONE_VAL; dat_lo = '0; dat_hi = asm_pkg::ONE_VAL;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      run_phase(100);
      set_axis(asm_pkg::MODE_LINEAR, 32'h0, 32'd800 << 16, -(32'sd1000 << 16),
               32'd1000 << 16);
      run_phase(140);
      // full range, reversed data axis
      set_axis(asm_pkg::MODE_PERCENT, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h80000000);
      run_phase(140);
      // equal screen bounds
      set_axis(asm_pkg::MODE_INDEXED, 32'd5 << 16, 32'd5 << 16, 32'h0, 32'd10 << 16);
      run_phase(80);
      // equal data bounds
      set_axis(asm_pkg::MODE_LINEAR, 32'h0, 32'd300 << 16, 32'd7 << 16, 32'd7 << 16);
      run_phase(80);
      set_axis(asm_pkg::MODE_LOG, 32'h0, 32'd600 << 16, 32'h1, 32'h7FFFFFFF);
      run_phase(180);
      set_axis(asm_pkg::MODE_LOG, 32'd600 << 16, 32'h0, asm_pkg::ONE_VAL, 32'd1000 << 16);
      run_phase(180);
      // equal log bounds
      set_axis(asm_pkg::MODE_LOG, 32'd2 << 16, 32'd50 << 16, 32'h40000, 32'h40000);
      run_phase(60);
      // non-positive lower data bound falls back to linear
      set_axis(asm_pkg::MODE_LOG, 32'h0, 32'd100 << 16, -32'sd5, 32'd100 << 16);
      run_phase(80);
      // tiny screen span: far extrapolation, overflow and underflow of exp2
      set_axis(asm_pkg::MODE_LOG, 32'h0, 32'h1, 32'h1000, 32'h100000);
      run_phase(140);
      // random settings
      for (int k = 0; k < 8; k++) begin
         m  = $urandom_range(3);
         dl = (m == asm_pkg::MODE_LOG && $urandom_range(3) != 0) ?
              $urandom_range(32'h7FFFFFFF, 1) : $urandom;
         dh = (m == asm_pkg::MODE_LOG && $urandom_range(3) != 0) ?
              $urandom_range(32'h7FFFFFFF, 1) : $urandom;
         set_axis(m, $urandom, $urandom, dl, dh);
         run_phase(110);
      end

      // drain
      req_tvalid <= 1'b0;
      rsp_steady  = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      $display("covered %0d items over %0d axis settings, %0d results compared",
               items_sent, settings_used + 1, checked);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #8ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
hdl/asm_pkg.sv
hdl/axis_scale_mapper_unit.sv
dv/scale_map_checker.sv
dv/axis_scale_mapper_unit_tb.sv
